[hdl/b64e_pkg.sv]
`timescale 1ns / 1ps

package b64e_pkg;

    // Configuration port geometry
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes (byte address divided by four)
    localparam logic REG_PAD_CHAR = 1'b0;

    localparam logic [7:0] PAD_CHAR_RESET = 8'd61;

    // Default depth of the group queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // How a group of three byte slots ends
    typedef enum logic [1:0] {
        GRP_FULL,
        GRP_PAD1,
        GRP_PAD2
    } grp_kind_t;

    // One group handed from the front to the back
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        grp_kind_t  kind;
        logic       last;
    } group_t;

    // Encoding alphabet
    localparam logic [7:0] ALPHABET [64] = '{
        "a", "b", "z", "0", "1", "2", "D", "V", "o", "p", "9", "+", "/", "A", "B", "t",
        "u", "v", "E", "F", "4", "5", "6", "7", "8", "O", "c", "d", "e", "f", "g", "h",
        "3", "m", "n", "T", "U", "w", "x", "y", "P", "Q", "R", "S", "C", "i", "j", "k",
        "l", "G", "H", "I", "J", "K", "L", "M", "N", "q", "r", "s", "W", "X", "Y", "Z"
    };

    function automatic logic [7:0] b64e_char(input logic [5:0] sextet);
        return ALPHABET[sextet];
    endfunction

endpackage

[hdl/b64e_ifs.sv]
`timescale 1ns / 1ps

// Byte channel: one message byte per transfer
interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Character channel: one encoded character per transfer
interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

[hdl/b64e_front.sv]
`timescale 1ns / 1ps

module b64e_front
    import b64e_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    b64e_byte_if.sink        byte_in,
    output logic             push_valid,
    input  logic             push_ready,
    output group_t           push_group
);

    logic [7:0] held_reg [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       accept;
    logic       emit;

    // Take a byte only when a group could be queued
    assign byte_in.ready = push_ready;
    assign accept        = byte_in.valid && push_ready;
    assign emit          = (count_reg == 2'd2) || byte_in.last_byte;
    assign push_valid    = byte_in.valid && emit;

    // Form the group from held bytes and the incoming byte
    always_comb
    begin
        push_group.last = byte_in.last_byte;
        case (count_reg)
            2'd0:
            begin
                push_group.b0   = byte_in.data_byte;
                push_group.b1   = 8'd0;
                push_group.b2   = 8'd0;
                push_group.kind = GRP_PAD2;
            end
            2'd1:
            begin
                push_group.b0   = held_reg[0];
                push_group.b1   = byte_in.data_byte;
                push_group.b2   = 8'd0;
                push_group.kind = GRP_PAD1;
            end
            default:
            begin
                push_group.b0   = held_reg[0];
                push_group.b1   = held_reg[1];
                push_group.b2   = byte_in.data_byte;
                push_group.kind = GRP_FULL;
            end
        endcase
    end

    // Advance the fill count, drop it when a group leaves
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (emit)
                count_next = 2'd0;
            else
                count_next = count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    // Hold pending bytes
    always_ff @(posedge clk)
    begin
        if (accept && !emit)
            held_reg[count_reg[0]] <= byte_in.data_byte;
    end

endmodule

[hdl/b64e_queue.sv]
`timescale 1ns / 1ps

module b64e_queue
    import b64e_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  group_t push_data,
    output logic   pop_valid,
    input  logic   pop_ready,
    output group_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    group_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store queued groups
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[hdl/b64e_back.sv]
`timescale 1ns / 1ps

module b64e_back
    import b64e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  group_t      pop_data,
    input  logic [7:0]  pad_char,
    b64e_char_if.source char_out
);

    logic        have_reg;
    logic        have_next;
    group_t      grp_reg;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic        ov_reg;
    logic        ov_next;
    logic [7:0]  oc_reg;
    logic        ol_reg;
    logic        load;
    logic        do_pop;
    logic [5:0]  sextet;
    logic        is_pad;
    logic [7:0]  char_val;
    logic        char_last;

    assign load      = have_reg && (!ov_reg || char_out.ready);
    assign pop_ready = !have_reg || (load && (idx_reg == 2'd3));
    assign do_pop    = pop_valid && pop_ready;

    // Pick the six-bit slice for the current position
    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = grp_reg.b0[7:2];
            2'd1:    sextet = {grp_reg.b0[1:0], grp_reg.b1[7:4]};
            2'd2:    sextet = {grp_reg.b1[3:0], grp_reg.b2[7:6]};
            default: sextet = grp_reg.b2[5:0];
        endcase
    end

    // Substitute the pad character at unused positions
    assign is_pad    = ((grp_reg.kind == GRP_PAD2) && idx_reg[1])
                    || ((grp_reg.kind == GRP_PAD1) && (idx_reg == 2'd3));
    assign char_val  = is_pad ? pad_char : b64e_char(sextet);
    assign char_last = (idx_reg == 2'd3) && ((grp_reg.kind != GRP_FULL) || grp_reg.last);

    // Step through the four positions of the held group
    always_comb
    begin
        have_next = have_reg;
        idx_next  = idx_reg;
        ov_next   = ov_reg;
        if (load)
        begin
            idx_next = idx_reg + 2'd1;
            ov_next  = 1'b1;
            if (idx_reg == 2'd3)
                have_next = 1'b0;
        end
        else if (char_out.ready)
        begin
            ov_next = 1'b0;
        end
        if (do_pop)
        begin
            have_next = 1'b1;
            idx_next  = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
            idx_reg  <= 2'd0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
            idx_reg  <= idx_next;
            ov_reg   <= ov_next;
        end
    end

    // Hold the group and the output character
    always_ff @(posedge clk)
    begin
        if (do_pop)
            grp_reg <= pop_data;
        if (load)
        begin
            oc_reg <= char_val;
            ol_reg <= char_last;
        end
    end

    assign char_out.valid     = ov_reg;
    assign char_out.out_char  = oc_reg;
    assign char_out.last_char = ol_reg;

endmodule

[hdl/base64_custom_alphabet_encoder.sv]
`timescale 1ns / 1ps
// A closed group passes the group queue, then the group register, then the output register.
// Throughput: one character per cycle from the back end while char_out is ready,
// four per group; the output register is the limit.
// The group queue lets the front take bytes while the back drains earlier groups.
// Reset (rst_n low, asynchronous): queue, group state and output valid cleared, pad_char = 61.

module base64_custom_alphabet_encoder
    import b64e_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    b64e_byte_if.sink             byte_in,
    b64e_char_if.source           char_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [7:0] pad_char_reg;
    logic       cfg_write;
    logic       push_valid;
    logic       push_ready;
    group_t     push_group;
    logic       pop_valid;
    logic       pop_ready;
    group_t     pop_group;

    // Register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pad_char_reg <= PAD_CHAR_RESET;
        else if (cfg_write && (paddr[2] == REG_PAD_CHAR))
            pad_char_reg <= pwdata[7:0];
    end

    always_comb
    begin
        case (paddr[2])
            REG_PAD_CHAR: prdata = {{(CFG_DATA_W-8){1'b0}}, pad_char_reg};
            default:      prdata = '0;
        endcase
    end

    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_group (push_group)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_group),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_group)
    );

    b64e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_group),
        .pad_char  (pad_char_reg),
        .char_out  (char_out)
    );

endmodule

[hdl/b64e_checker.sv]
`timescale 1ns / 1ps

module b64e_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       out_last
);

    logic [1:0] held_reg;
    logic [1:0] pos_reg;
    logic [5:0] owed_reg;
    logic       in_xfer;
    logic       out_xfer;
    logic       closes;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;
    assign closes   = in_last || (held_reg == 2'd2);

    // Track group fill, character position and characters still owed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 2'd0;
            pos_reg  <= 2'd0;
            owed_reg <= 6'd0;
        end
        else
        begin
            if (in_xfer)
                held_reg <= closes ? 2'd0 : held_reg + 2'd1;
            if (out_xfer)
                pos_reg <= pos_reg + 2'd1;
            owed_reg <= owed_reg + ((in_xfer && closes) ? 6'd4 : 6'd0)
                                 - (out_xfer ? 6'd1 : 6'd0);
        end
    end

    // No character without a closed group behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (owed_reg != 6'd0))
        else $error("character shown with no group pending");

    // The final mark only on the fourth character of a group
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && out_last) |-> (pos_reg == 2'd3))
        else $error("last_char away from a group boundary");

    // A stalled character holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_char) && $stable(out_last)))
        else $error("stalled character changed");

endmodule

bind base64_custom_alphabet_encoder b64e_checker u_b64e_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (byte_in.valid),
    .in_ready  (byte_in.ready),
    .in_last   (byte_in.last_byte),
    .out_valid (char_out.valid),
    .out_ready (char_out.ready),
    .out_char  (char_out.out_char),
    .out_last  (char_out.last_char)
);

[tb/tb_base64_custom_alphabet_encoder.sv]
`timescale 1ns / 1ps

module tb_base64_custom_alphabet_encoder;
    import b64e_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PHASE_BYTES    = 33;
    localparam logic [CFG_ADDR_W-1:0] PAD_CHAR_ADDR = CFG_ADDR_W'({REG_PAD_CHAR, 2'b00});

    // Encoding alphabet, first character in the top byte
    localparam logic [8*64-1:0] ENC_ALPHABET =
        "abz012DVop9+/ABtuvEF45678Ocdefgh3mnTUwxyPQRSCijklGHIJKLMNqrsWXYZ";

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } enc_char_t;

    function automatic logic [7:0] glyph(input logic [5:0] sextet);
        return ENC_ALPHABET[8*(63 - sextet) +: 8];
    endfunction

    // Tracks the group being built and the characters still owed by the block
    class b64_char_tracker;
        logic [7:0] pad;
        logic [7:0] held [2];
        logic [1:0] group_fill;
        enc_char_t  pending_chars [$];
        int         mismatches;

        function new();
            pad        = PAD_CHAR_RESET;
            held[0]    = 8'h00;
            held[1]    = 8'h00;
            group_fill = 2'd0;
            mismatches = 0;
        endfunction

        function void push(input logic [7:0] ch, input logic fin);
            enc_char_t c;
            c.ch  = ch;
            c.fin = fin;
            pending_chars.push_back(c);
        endfunction

        // Note one accepted byte and queue the characters it releases
        function void take_byte(input logic [7:0] b, input logic fin);
            logic [7:0] b0;
            logic [7:0] b1;
            logic [7:0] b2;
            if (group_fill < 2'd2 && !fin)
            begin
                held[group_fill[0]] = b;
                group_fill          = group_fill + 2'd1;
                return;
            end
            b0 = (group_fill == 2'd0) ? b : held[0];
            b1 = (group_fill == 2'd0) ? 8'h00 : ((group_fill == 2'd1) ? b : held[1]);
            b2 = (group_fill == 2'd2) ? b : 8'h00;
            push(glyph(b0[7:2]), 1'b0);
            push(glyph({b0[1:0], b1[7:4]}), 1'b0);
            case (group_fill)
                2'd0:
                begin
                    push(pad, 1'b0);
                    push(pad, 1'b1);
                end
                2'd1:
                begin
                    push(glyph({b1[3:0], 2'b00}), 1'b0);
                    push(pad, 1'b1);
                end
                default:
                begin
                    push(glyph({b1[3:0], b2[7:6]}), 1'b0);
                    push(glyph(b2[5:0]), fin);
                end
            endcase
            held[0]    = 8'h00;
            held[1]    = 8'h00;
            group_fill = 2'd0;
        endfunction

        // Compare one accepted character with the oldest one owed
        function void match_char(input logic [7:0] ch, input logic fin);
            enc_char_t exp_c;
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected character %h last %b", $time, ch, fin);
                mismatches++;
                return;
            end
            exp_c = pending_chars.pop_front();
            if (ch !== exp_c.ch)
            begin
                $display("%0t: out_char mismatch: expected %h, actual %h",
                         $time, exp_c.ch, ch);
                mismatches++;
            end
            if (fin !== exp_c.fin)
            begin
                $display("%0t: last_char mismatch: expected %b, actual %b",
                         $time, exp_c.fin, fin);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    bit                    idle_en;
    int                    stall_count;
    b64_char_tracker       tracker;

    b64e_byte_if byte_if ();
    b64e_char_if char_if ();

    base64_custom_alphabet_encoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (byte_if),
        .char_out (char_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_en)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one byte and hold it until the transfer
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_if.valid     <= 1'b1;
        byte_if.data_byte <= b;
        byte_if.last_byte <= fin;
        do
            @(posedge clk);
        while (!(byte_if.valid && byte_if.ready));
        tracker.take_byte(b, fin);
    endtask

    task automatic send_message(input int len);
        int         r;
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                b = 8'h00;
            else if (r == 1)
                b = 8'hFF;
            else
                b = 8'($urandom);
            send_byte(b, i == len - 1);
        end
    endtask

    // Drop valid and wait until every owed character has come out
    task automatic wait_drain();
        byte_if.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Setup then access cycle; the write lands when pready is seen
    task automatic write_pad(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PAD_CHAR_ADDR;
        pwdata  <= CFG_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.pad = value;
    endtask

    task automatic random_phase(input int quota);
        int sent;
        int len;
        sent = 0;
        while (sent < quota)
        begin
            len     = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 9)
                                                 : $urandom_range(10, 20);
            idle_en = ($urandom_range(0, 4) != 0);
            send_message(len);
            sent += len;
            if ($urandom_range(0, 7) == 0)
                wait_drain();
        end
        idle_en = 1'b1;
        wait_drain();
    endtask

    // Receiver: random runs of ready with random stalls between them
    initial
    begin
        char_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            int gap;
            gap = pick_gap();
            if (gap > 0)
            begin
                char_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            char_if.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Check every character transfer
    always @(posedge clk)
    begin
        if (rst_n && char_if.valid && char_if.ready)
            tracker.match_char(char_if.out_char, char_if.last_char);
    end

    // Watchdog: count cycles with no transfer on any port
    always @(posedge clk)
    begin
        if (!rst_n || (byte_if.valid && byte_if.ready) || (char_if.valid && char_if.ready)
            || (psel && penable))
            stall_count <= 0;
        else
        begin
            stall_count <= stall_count + 1;
            if (stall_count >= WATCHDOG_LIMIT)
            begin
                $display("tb_base64_custom_alphabet_encoder NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        tracker           = new();
        idle_en           = 1'b1;
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        byte_if.valid     <= 1'b0;
        byte_if.data_byte <= 8'h00;
        byte_if.last_byte <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-byte messages: two pads
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // Two-byte messages: one pad
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        // Full groups closed by the last byte
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        // One full group, then a tail of one byte
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        send_byte(8'hA5, 1'b1);
        // One full group, then a tail of two bytes
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(8'h9A, 1'b1);
        wait_drain();

        // Random messages under several pad characters
        write_pad(8'h00);
        random_phase(PHASE_BYTES);
        write_pad(8'hFF);
        random_phase(PHASE_BYTES);
        write_pad(8'($urandom));
        random_phase(PHASE_BYTES);
        write_pad(PAD_CHAR_RESET);
        random_phase(PHASE_BYTES);

        if (tracker.mismatches == 0 && tracker.pending_chars.size() == 0)
            $display("tb_base64_custom_alphabet_encoder OK");
        else
            $display("tb_base64_custom_alphabet_encoder NOT OK");
        $finish;
    end

endmodule

[sim.f]
hdl/b64e_pkg.sv
hdl/b64e_ifs.sv
hdl/b64e_front.sv
hdl/b64e_queue.sv
hdl/b64e_back.sv
hdl/base64_custom_alphabet_encoder.sv
hdl/b64e_checker.sv
tb/tb_base64_custom_alphabet_encoder.sv
